// File: rtl/cfb_pkg.sv
// Shared types, constants and the CRC byte update for the CRC-16 frame builder.
// Used by the front end, the command queue, the back end and the top level.
package cfb_pkg;

  // Default number of entries in the command queue between front and back.
  localparam int QUEUE_DEPTH_DEF = 4;

  // CRC-16/CCITT-FALSE constants.
  localparam logic [15:0] CRC_SEED = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // Reset values of the configuration registers.
  localparam logic [7:0]  SYNC_FIRST_RST  = 8'hAA;
  localparam logic [7:0]  SYNC_SECOND_RST = 8'h55;
  localparam logic [15:0] CAPACITY_RST    = 16'd256;

  // Frame overhead in bytes: two sync, sequence, command, two length, two CRC.
  localparam logic [16:0] FRAME_OVERHEAD = 17'd8;

  // Configuration register indexes.
  localparam logic [1:0] CFG_SYNC_FIRST  = 2'd0;
  localparam logic [1:0] CFG_SYNC_SECOND = 2'd1;
  localparam logic [1:0] CFG_CAPACITY    = 2'd2;

  // Result status codes.
  localparam logic [1:0] STATUS_FRAME    = 2'd0;
  localparam logic [1:0] STATUS_REJECTED = 2'd1;
  localparam logic [1:0] STATUS_ORPHAN   = 2'd2;

  // Kind of work that the front end hands to the back end.
  typedef enum logic [1:0] {
    KIND_START,
    KIND_DATA,
    KIND_REJECT,
    KIND_ORPHAN
  } kind_e;

  // One queue entry. For a start, data is the command byte; for data, the payload byte.
  // crc_end is set when the entry closes the frame with its CRC.
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data;
    logic [7:0]  seq;
    logic [15:0] plen;
    logic        crc_end;
  } q_entry_t;

  // Queue fill status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  // Feed one byte into the CRC, MSB first.
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

// File: rtl/cfb_front.sv
// Front end of the frame builder: accepts input beats, checks capacity and frame state,
// and pushes one classified entry per beat into the command queue. Depends on cfb_pkg.
module cfb_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              op_i,
  input  logic [7:0]        command_i,
  input  logic [15:0]       payload_length_i,
  input  logic [7:0]        payload_byte_i,
  input  logic [15:0]       frame_capacity_i,
  input  cfb_pkg::qstat_t   qstat_i,
  output logic              push_o,
  output cfb_pkg::q_entry_t entry_o
);
  import cfb_pkg::*;

  logic [7:0]  seq_q, seq_d;
  logic        open_q, open_d;
  logic [15:0] remaining_q, remaining_d;
  logic        accept;
  logic [16:0] total;

  // A beat is taken whenever the queue has room.
  assign in_stall_o = qstat_i.full;
  assign accept     = in_valid_i && !qstat_i.full;
  assign push_o     = accept;
  assign total      = {1'b0, payload_length_i} + FRAME_OVERHEAD;

  // Classify the beat and update the frame bookkeeping.
  always_comb begin
    seq_d         = seq_q;
    open_d        = open_q;
    remaining_d   = remaining_q;
    entry_o.kind  = KIND_ORPHAN;
    entry_o.data  = command_i;
    entry_o.seq   = seq_q;
    entry_o.plen  = payload_length_i;
    entry_o.crc_end = 1'b0;
    if (!op_i) begin
      // A start abandons any open frame.
      open_d      = 1'b0;
      remaining_d = '0;
      if (total > {1'b0, frame_capacity_i}) begin
        entry_o.kind = KIND_REJECT;
      end else begin
        entry_o.kind    = KIND_START;
        entry_o.crc_end = (payload_length_i == '0);
        seq_d           = seq_q + 8'd1;
        if (payload_length_i != '0) begin
          open_d      = 1'b1;
          remaining_d = payload_length_i;
        end
      end
    end else begin
      entry_o.data = payload_byte_i;
      if (open_q) begin
        entry_o.kind    = KIND_DATA;
        entry_o.crc_end = (remaining_q == 16'd1);
        remaining_d     = remaining_q - 16'd1;
        if (remaining_q == 16'd1) begin
          open_d = 1'b0;
        end
      end
    end
  end

  // State registers change only on an accepted beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q       <= '0;
      open_q      <= 1'b0;
      remaining_q <= '0;
    end else if (accept) begin
      seq_q       <= seq_d;
      open_q      <= open_d;
      remaining_q <= remaining_d;
    end
  end

endmodule

// File: rtl/cfb_queue.sv
// Short command queue that decouples the front end from the back end.
// Holds cfb_pkg::q_entry_t entries; depends on cfb_pkg.
module cfb_queue #(
  parameter int QDEPTH = cfb_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  cfb_pkg::q_entry_t entry_i,
  input  logic              pop_i,
  output cfb_pkg::q_entry_t head_o,
  output cfb_pkg::qstat_t   qstat_o
);
  import cfb_pkg::*;

  localparam int PtrW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CntW = $clog2(QDEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(QDEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(QDEPTH);

  q_entry_t        mem_q [QDEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign head_o        = mem_q[rd_ptr_q];
  assign qstat_o.full  = (count_q == CntFull);
  assign qstat_o.empty = (count_q == '0);

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

// File: rtl/cfb_back.sv
// Back end of the frame builder: walks each queue entry beat by beat, runs the CRC,
// and drives the registered output channel. Depends on cfb_pkg.
module cfb_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfb_pkg::q_entry_t head_i,
  input  cfb_pkg::qstat_t   qstat_i,
  output logic              pop_o,
  input  logic [7:0]        sync_first_i,
  input  logic [7:0]        sync_second_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [7:0]        frame_byte_o,
  output logic              last_o,
  output logic [1:0]        status_o,
  output logic              frame_end_o
);
  import cfb_pkg::*;

  logic [2:0]  beat_q, beat_d;
  logic [15:0] crc_q, crc_d;
  logic        out_valid_q, out_valid_d;
  logic [7:0]  byte_q;
  logic        last_q, frame_end_q;
  logic [1:0]  status_q;

  logic        advance;
  logic [7:0]  beat_byte;
  logic        beat_feed, beat_last, beat_end;
  logic [1:0]  beat_status;
  logic [15:0] crc_base;

  // Move on when an entry is waiting and the output register is free or draining.
  assign advance = !qstat_i.empty && (!out_valid_q || !out_stall_i);
  assign pop_o   = advance && beat_last;

  // Decode the current beat of the head entry.
  always_comb begin
    beat_byte   = '0;
    beat_feed   = 1'b0;
    beat_last   = 1'b1;
    beat_end    = 1'b0;
    beat_status = STATUS_FRAME;
    case (head_i.kind)
      KIND_START: begin
        case (beat_q)
          3'd0:    beat_byte = sync_first_i;
          3'd1:    beat_byte = sync_second_i;
          3'd2:    beat_byte = head_i.seq;
          3'd3:    beat_byte = head_i.data;
          3'd4:    beat_byte = head_i.plen[7:0];
          3'd5:    beat_byte = head_i.plen[15:8];
          3'd6:    beat_byte = crc_q[7:0];
          default: beat_byte = crc_q[15:8];
        endcase
        beat_feed = (beat_q >= 3'd2) && (beat_q <= 3'd5);
        beat_last = head_i.crc_end ? (beat_q == 3'd7) : (beat_q == 3'd5);
        beat_end  = (beat_q == 3'd7);
      end
      KIND_DATA: begin
        case (beat_q)
          3'd0:    beat_byte = head_i.data;
          3'd1:    beat_byte = crc_q[7:0];
          default: beat_byte = crc_q[15:8];
        endcase
        beat_feed = (beat_q == 3'd0);
        beat_last = head_i.crc_end ? (beat_q == 3'd2) : (beat_q == 3'd0);
        beat_end  = (beat_q == 3'd2);
      end
      KIND_REJECT: begin
        beat_status = STATUS_REJECTED;
      end
      default: begin
        beat_status = STATUS_ORPHAN;
      end
    endcase
  end

  // The sequence byte of a frame starts the CRC over from the seed.
  assign crc_base = ((head_i.kind == KIND_START) && (beat_q == 3'd2)) ? CRC_SEED : crc_q;

  // Next values of the beat counter, CRC and output valid.
  always_comb begin
    beat_d      = beat_q;
    crc_d       = crc_q;
    out_valid_d = out_valid_q;
    if (advance) begin
      beat_d      = beat_last ? 3'd0 : beat_q + 3'd1;
      out_valid_d = 1'b1;
      if (beat_feed) begin
        crc_d = crc_feed(crc_base, beat_byte);
      end
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_q      <= '0;
      crc_q       <= CRC_SEED;
      out_valid_q <= 1'b0;
    end else begin
      beat_q      <= beat_d;
      crc_q       <= crc_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      byte_q      <= beat_byte;
      last_q      <= beat_last;
      status_q    <= beat_status;
      frame_end_q <= beat_end;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign frame_byte_o = byte_q;
  assign last_o       = last_q;
  assign status_o     = status_q;
  assign frame_end_o  = frame_end_q;

  // The CRC high byte always closes the work of its input beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && frame_end_q |-> last_q)
    else $error("frame end without last");

  // Rejected and orphan results are single zero beats.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (status_q != STATUS_FRAME) |-> last_q && (byte_q == 8'h00) && !frame_end_q)
    else $error("error result is not a single zero beat");

  // An entry in progress stays at the head of the queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (beat_q != 3'd0) |-> !qstat_i.empty)
    else $error("beat counter running with empty queue");

  // A stalled result is held.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |=> out_valid_q && $stable(byte_q) && $stable(last_q))
    else $error("stalled result changed");

endmodule

// File: rtl/crc16_frame_builder_unit.sv
// Top level of the CRC-16 frame builder: configuration registers, front end, command queue
// and back end. Depends on cfb_pkg, cfb_front, cfb_queue and cfb_back.
//
//   Channel  Direction  Handshake              Fields
//   input    in         in_valid_i/in_stall_o   op, command, payload_length, payload_byte
//   result   out        out_valid_o/out_stall_i frame_byte, last, status, frame_end
//   config   in         cfg_we_i                cfg_idx_i, cfg_wdata_i
//
// Input beats are taken one per cycle while the command queue has room. Unless stalled, the
// back end issues one result beat per cycle: a start gives six beats (eight with a zero
// length), a payload byte one beat (three when it closes the frame), errors one beat.
// Reset restores the default sync bytes and capacity and clears the sequence number.
// An output stall holds the result register; the queue absorbs input until it fills.
module crc16_frame_builder_unit #(
  parameter int QUEUE_DEPTH = cfb_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        op_i,
  input  logic [7:0]  command_i,
  input  logic [15:0] payload_length_i,
  input  logic [7:0]  payload_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  frame_byte_o,
  output logic        last_o,
  output logic [1:0]  status_o,
  output logic        frame_end_o
);
  import cfb_pkg::*;

  logic [7:0]  sync_first_q;
  logic [7:0]  sync_second_q;
  logic [15:0] capacity_q;

  logic        push;
  logic        pop;
  q_entry_t    entry;
  q_entry_t    head;
  qstat_t      qstat;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_first_q  <= SYNC_FIRST_RST;
      sync_second_q <= SYNC_SECOND_RST;
      capacity_q    <= CAPACITY_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SYNC_FIRST:  sync_first_q  <= cfg_wdata_i[7:0];
        CFG_SYNC_SECOND: sync_second_q <= cfg_wdata_i[7:0];
        CFG_CAPACITY:    capacity_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Front end: accept and classify.
  cfb_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .op_i             (op_i),
    .command_i        (command_i),
    .payload_length_i (payload_length_i),
    .payload_byte_i   (payload_byte_i),
    .frame_capacity_i (capacity_q),
    .qstat_i          (qstat),
    .push_o           (push),
    .entry_o          (entry)
  );

  // Command queue between the two sides.
  cfb_queue #(
    .QDEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .pop_i   (pop),
    .head_o  (head),
    .qstat_o (qstat)
  );

  // Back end: frame bytes, CRC and output register.
  cfb_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .qstat_i       (qstat),
    .pop_o         (pop),
    .sync_first_i  (sync_first_q),
    .sync_second_i (sync_second_q),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .frame_byte_o  (frame_byte_o),
    .last_o        (last_o),
    .status_o      (status_o),
    .frame_end_o   (frame_end_o)
  );

endmodule

// File: sim/crc16_frame_builder_unit_tb.sv
// Self-checking testbench for crc16_frame_builder_unit: a directed stimulus table, then random
// framed traffic. Every result beat is checked against a predictor kept here; uses cfb_pkg only.
module crc16_frame_builder_unit_tb;
  import cfb_pkg::*;

  localparam logic       OP_START       = 1'b0;
  localparam logic       OP_DATA        = 1'b1;
  localparam logic [1:0] CFG_SPARE      = 2'd3;
  localparam int         MAX_REPORTS    = 10;
  localparam int         FULL_FRAME_MAX = 40;
  localparam int         PHASE_BEATS    = 25;
  localparam int         WRAP_STARTS    = 260;

  typedef struct packed {
    logic        op;
    logic [7:0]  cmd;
    logic [15:0] len;
    logic [7:0]  pbyte;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] fbyte;
    logic       last;
    logic [1:0] status;
    logic       fend;
  } frame_res_t;

  // One row of the directed table: either a register write or an input beat. A nonzero
  // typed status replaces the predicted result with a single error beat of that status.
  typedef struct {
    logic       is_cfg;
    logic [1:0] idx;
    logic [15:0] val;
    in_beat_t   beat;
    logic [1:0] typed_status;
  } plan_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = 2'd0;
  logic [15:0] cfg_wdata_i = 16'd0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        op_i = 1'b0;
  logic [7:0]  command_i = 8'd0;
  logic [15:0] payload_length_i = 16'd0;
  logic [7:0]  payload_byte_i = 8'd0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  frame_byte_o;
  logic        last_o;
  logic [1:0]  status_o;
  logic        frame_end_o;

  // Predictor state and its copy of the configuration.
  logic [7:0]  sync_a, sync_b;
  logic [15:0] cap;
  logic [7:0]  seq_no;
  logic [15:0] crc_acc;
  logic [15:0] bytes_left;
  logic        frame_is_open;

  frame_res_t  frame_bytes_due[$];
  plan_row_t   plan[$];

  int beats_sent = 0;
  int burst_left = 0;
  int results_seen = 0;
  int frames_closed = 0;
  int rejects_seen = 0;
  int orphans_seen = 0;
  int fail_cnt = 0;
  int stall_cyc = 0;

  crc16_frame_builder_unit dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .op_i             (op_i),
    .command_i        (command_i),
    .payload_length_i (payload_length_i),
    .payload_byte_i   (payload_byte_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .frame_byte_o     (frame_byte_o),
    .last_o           (last_o),
    .status_o         (status_o),
    .frame_end_o      (frame_end_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Run limit, far above the slowest correct run.
  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Output stall: cycles through no stall, sparse random, periodic and heavy random stretches.
  always @(negedge clk_i) begin
    stall_cyc <= stall_cyc + 1;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      case ((stall_cyc / 150) % 4)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= ($urandom_range(0, 3) == 0);
        2: out_stall_i <= (stall_cyc % 3 == 0);
        default: out_stall_i <= 1'($urandom_range(0, 1));
      endcase
    end
  end

  // CRC-16/CCITT-FALSE update, one bit at a time from the MSB of the byte.
  function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] d);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ d[i];
      c = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
    end
    return c;
  endfunction

  task automatic add_res(input logic [7:0] b, input logic [1:0] st, input logic fe);
    frame_bytes_due.push_back('{fbyte: b, last: 1'b0, status: st, fend: fe});
  endtask

  task automatic add_crc_byte(input logic [7:0] b);
    crc_acc = crc_step(crc_acc, b);
    add_res(b, STATUS_FRAME, 1'b0);
  endtask

  task automatic close_frame();
    add_res(crc_acc[7:0], STATUS_FRAME, 1'b0);
    add_res(crc_acc[15:8], STATUS_FRAME, 1'b1);
    frame_is_open = 1'b0;
    bytes_left = 16'd0;
  endtask

  // Work out every result beat that one input beat causes and queue them in order.
  task automatic predict_frame_bytes(input in_beat_t b);
    frame_res_t r;
    logic [16:0] total;
    if (b.op == OP_START) begin
      total = FRAME_OVERHEAD + {1'b0, b.len};
      frame_is_open = 1'b0;
      bytes_left = 16'd0;
      if (total > {1'b0, cap}) begin
        add_res(8'h00, STATUS_REJECTED, 1'b0);
      end else begin
        crc_acc = CRC_SEED;
        add_res(sync_a, STATUS_FRAME, 1'b0);
        add_res(sync_b, STATUS_FRAME, 1'b0);
        add_crc_byte(seq_no);
        seq_no = seq_no + 8'd1;
        add_crc_byte(b.cmd);
        add_crc_byte(b.len[7:0]);
        add_crc_byte(b.len[15:8]);
        if (b.len == 16'd0) begin
          close_frame();
        end else begin
          frame_is_open = 1'b1;
          bytes_left = b.len;
        end
      end
    end else if (!frame_is_open) begin
      add_res(8'h00, STATUS_ORPHAN, 1'b0);
    end else begin
      add_crc_byte(b.pbyte);
      bytes_left = bytes_left - 16'd1;
      if (bytes_left == 16'd0) close_frame();
    end
    // The final beat of this input carries last.
    r = frame_bytes_due.pop_back();
    r.last = 1'b1;
    frame_bytes_due.push_back(r);
  endtask

  // Drive one input beat in a burst pattern and hold it until the block takes it.
  task automatic send_beat(input in_beat_t b, input logic [1:0] typed_status);
    int gap;
    @(negedge clk_i);
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid_i       <= 1'b1;
    op_i             <= b.op;
    command_i        <= b.cmd;
    payload_length_i <= b.len;
    payload_byte_i   <= b.pbyte;
    predict_frame_bytes(b);
    if (typed_status != STATUS_FRAME) begin
      void'(frame_bytes_due.pop_back());
      frame_bytes_due.push_back('{fbyte: 8'h00, last: 1'b1, status: typed_status, fend: 1'b0});
    end
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    burst_left--;
    beats_sent++;
  endtask

  // Stop sending and wait until every predicted beat has come out, plus a short margin.
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (frame_bytes_due.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_SYNC_FIRST:  sync_a = val[7:0];
      CFG_SYNC_SECOND: sync_b = val[7:0];
      CFG_CAPACITY:    cap = val;
      default: ;
    endcase
  endtask

  function automatic in_beat_t mk_start(input logic [7:0] cmd, input logic [15:0] len);
    logic [7:0] junk;
    junk = 8'($urandom);
    return '{op: OP_START, cmd: cmd, len: len, pbyte: junk};
  endfunction

  function automatic in_beat_t mk_data(input logic [7:0] pb);
    logic [7:0]  junk_cmd;
    logic [15:0] junk_len;
    junk_cmd = 8'($urandom);
    junk_len = 16'($urandom);
    return '{op: OP_DATA, cmd: junk_cmd, len: junk_len, pbyte: pb};
  endfunction

  task automatic plan_beat(input in_beat_t b, input logic [1:0] typed_status);
    plan.push_back('{is_cfg: 1'b0, idx: 2'd0, val: 16'd0, beat: b, typed_status: typed_status});
  endtask

  task automatic plan_cfg(input logic [1:0] idx, input logic [15:0] val);
    plan.push_back('{is_cfg: 1'b1, idx: idx, val: val, beat: '0, typed_status: STATUS_FRAME});
  endtask

  // Payload length for a random frame: mostly short, some at the capacity edge, some wild.
  function automatic logic [15:0] pick_len();
    int r, edge_len;
    r = $urandom_range(0, 99);
    if (r < 55) return 16'($urandom_range(0, 12));
    if (r < 70) begin
      edge_len = int'(cap) - 8 + int'($urandom_range(0, 2)) - 1;
      if (edge_len < 0) edge_len = 0;
      if (edge_len > 65535) edge_len = 65535;
      return 16'(edge_len);
    end
    if (r < 85) return 16'($urandom);
    return 16'($urandom_range(13, 64));
  endfunction

  // Random traffic: mostly whole frames, some cut short, some stray beats.
  task automatic run_mix(input int quota);
    int stop_at, sel, n;
    logic [15:0] len;
    logic        fits;
    stop_at = beats_sent + quota;
    while (beats_sent < stop_at) begin
      sel = $urandom_range(0, 99);
      if (sel < 80) begin
        len = pick_len();
        fits = (8 + int'(len)) <= int'(cap);
        send_beat(mk_start(8'($urandom), len), STATUS_FRAME);
        if (fits) begin
          n = (int'(len) <= FULL_FRAME_MAX) ? int'(len) : $urandom_range(0, 16);
          repeat (n) send_beat(mk_data(8'($urandom)), STATUS_FRAME);
        end
      end else if (sel < 90) begin
        len = 16'($urandom_range(2, 20));
        send_beat(mk_start(8'($urandom), len), STATUS_FRAME);
        if ((8 + int'(len)) <= int'(cap)) begin
          repeat ($urandom_range(0, int'(len) - 1))
            send_beat(mk_data(8'($urandom)), STATUS_FRAME);
        end
      end else if (sel < 95) begin
        send_beat(mk_data(8'($urandom)), STATUS_FRAME);
      end else begin
        send_beat(mk_start(8'($urandom), 16'($urandom)), STATUS_FRAME);
      end
      // Now and then hold the sender until the block has drained completely.
      if ($urandom_range(0, 29) == 0) settle();
    end
  endtask

  task automatic report(input frame_res_t want, input frame_res_t got, input logic extra);
    fail_cnt++;
    if (fail_cnt <= MAX_REPORTS) begin
      if (extra) begin
        $display("%0t: unexpected beat byte=%h last=%b status=%0d end=%b", $realtime,
                 got.fbyte, got.last, got.status, got.fend);
      end else begin
        $display("%0t: mismatch exp byte=%h last=%b status=%0d end=%b", $realtime,
                 want.fbyte, want.last, want.status, want.fend);
        $display("%0t:          got byte=%h last=%b status=%0d end=%b", $realtime,
                 got.fbyte, got.last, got.status, got.fend);
      end
    end
  endtask

  // Result checker: each accepted result beat against the oldest predicted one.
  always @(posedge clk_i) begin : result_check
    frame_res_t got, want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{fbyte: frame_byte_o, last: last_o, status: status_o, fend: frame_end_o};
      results_seen++;
      if (got.fend) frames_closed++;
      if (got.status == STATUS_REJECTED) rejects_seen++;
      if (got.status == STATUS_ORPHAN) orphans_seen++;
      if (frame_bytes_due.size() == 0) begin
        report(got, got, 1'b1);
      end else begin
        want = frame_bytes_due.pop_front();
        if (got !== want) report(want, got, 1'b0);
      end
    end
  end

  initial begin
    int waited;
    logic [15:0] w1, w2;

    sync_a = SYNC_FIRST_RST;
    sync_b = SYNC_SECOND_RST;
    cap = CAPACITY_RST;
    seq_no = 8'd0;
    crc_acc = CRC_SEED;
    bytes_left = 16'd0;
    frame_is_open = 1'b0;

    // Directed table. Runs from the reset configuration: sync 0xAA 0x55, capacity 256.
    plan_beat(mk_data(8'hFF), STATUS_ORPHAN);             // payload with nothing open
    plan_beat(mk_start(8'h00, 16'd0), STATUS_FRAME);      // zero length closes at once
    plan_beat(mk_start(8'hFF, 16'd248), STATUS_FRAME);    // exactly at capacity
    plan_beat(mk_data(8'h00), STATUS_FRAME);
    plan_beat(mk_start(8'hA5, 16'd249), STATUS_REJECTED); // one over, abandons open frame
    plan_beat(mk_data(8'h12), STATUS_ORPHAN);
    plan_beat(mk_start(8'h3C, 16'hFFFF), STATUS_REJECTED); // length sum needs 17 bits
    plan_beat(mk_start(8'h5A, 16'd3), STATUS_FRAME);
    plan_beat(mk_data(8'h00), STATUS_FRAME);
    plan_beat(mk_data(8'hFF), STATUS_FRAME);
    plan_beat(mk_data(8'h80), STATUS_FRAME);
    plan_beat(mk_data(8'hAA), STATUS_ORPHAN);
    plan_beat(mk_start(8'hC3, 16'd1), STATUS_FRAME);
    plan_beat(mk_data(8'h55), STATUS_FRAME);
    // Largest capacity, sync bytes at the extremes with junk in the upper data bits.
    plan_cfg(CFG_CAPACITY, 16'hFFFF);
    plan_cfg(CFG_SYNC_FIRST, 16'hFF00);
    plan_cfg(CFG_SYNC_SECOND, 16'h00FF);
    plan_cfg(CFG_SPARE, 16'hFFFF);
    plan_beat(mk_start(8'h81, 16'hFFF7), STATUS_FRAME);
    plan_beat(mk_data(8'h01), STATUS_FRAME);
    plan_beat(mk_data(8'hFE), STATUS_FRAME);
    plan_beat(mk_start(8'h7E, 16'hFFF8), STATUS_REJECTED);
    // No frame fits at capacity zero; at eight only an empty one does.
    plan_cfg(CFG_CAPACITY, 16'h0000);
    plan_beat(mk_start(8'h11, 16'd0), STATUS_REJECTED);
    plan_cfg(CFG_CAPACITY, 16'd8);
    plan_cfg(CFG_SYNC_FIRST, 16'h00FF);
    plan_cfg(CFG_SYNC_SECOND, 16'h0000);
    plan_beat(mk_start(8'h22, 16'd0), STATUS_FRAME);
    plan_beat(mk_start(8'h33, 16'd1), STATUS_REJECTED);

    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        settle();
        write_reg(plan[i].idx, plan[i].val);
      end else begin
        send_beat(plan[i].beat, plan[i].typed_status);
      end
    end

    // Random phases, each under its own configuration.
    for (int ph = 0; ph < 4; ph++) begin
      settle();
      w1 = 16'($urandom);
      w2 = 16'($urandom);
      case (ph)
        0: begin
          write_reg(CFG_SYNC_FIRST, {w1[15:8], SYNC_FIRST_RST});
          write_reg(CFG_SYNC_SECOND, {w2[15:8], SYNC_SECOND_RST});
          write_reg(CFG_CAPACITY, CAPACITY_RST);
        end
        1: begin
          write_reg(CFG_SYNC_FIRST, w1);
          write_reg(CFG_SYNC_SECOND, w2);
          write_reg(CFG_CAPACITY, 16'($urandom_range(9, 40)));
        end
        2: begin
          write_reg(CFG_SYNC_FIRST, {w1[15:8], 8'hFF});
          write_reg(CFG_SYNC_SECOND, {w2[15:8], 8'h00});
          write_reg(CFG_CAPACITY, 16'hFFFF);
        end
        default: begin
          write_reg(CFG_SYNC_FIRST, w2);
          write_reg(CFG_SYNC_SECOND, w1);
          write_reg(CFG_CAPACITY, 16'($urandom_range(300, 600)));
        end
      endcase
      run_mix(PHASE_BEATS);
    end

    // Enough empty frames to carry the sequence number through its wrap.
    settle();
    write_reg(CFG_CAPACITY, 16'd8);
    repeat (WRAP_STARTS) send_beat(mk_start(8'($urandom), 16'd0), STATUS_FRAME);

    // Drain, then watch a little longer for stray beats.
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (frame_bytes_due.size() != 0) @(negedge clk_i);
    waited = 0;
    while (waited < 20) begin
      @(negedge clk_i);
      waited++;
    end

    if (frame_bytes_due.size() != 0) begin
      $display("%0d predicted beats never arrived", frame_bytes_due.size());
      fail_cnt++;
    end
    $display("Sent %0d input beats and checked %0d result beats.", beats_sent, results_seen);
    $display("Closed %0d frames, saw %0d rejections and %0d stray payload beats, %0d failures.",
             frames_closed, rejects_seen, orphans_seen, fail_cnt);
    if (fail_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
